### hw/rtl/slcfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slcfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned CRC_W  = 16;

  // configuration register indexes
  localparam logic CFG_SYNC_BYTE   = 1'b0;
  localparam logic CFG_MAX_PAYLOAD = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET   = 8'h55;
  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd100;
  localparam logic [CRC_W-1:0]  CRC_INIT          = 16'hFFFF;

  // one byte of CRC-16/CCITT-FALSE, MSB first, poly 0x1021
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'h0, x[7:4]};
    crc_step = {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
             ^ {8'h00, x};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sync_length_crc_frame_receiver_top.sv
// Frame receiver: sync, sync, length, type, data, CRC-16 (little-endian).
// Latency: a result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the only backpressure is a held result in
// the output register while out_stall is high.
// Reset (synchronous, rst high): parser hunts the first sync byte, output
// register empty, sync_byte = 0x55, max_payload = 100.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_crc_frame_receiver_top (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  // byte input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  // results
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            end_of_frame,
  output logic [7:0]      payload_byte,
  output logic [7:0]      byte_index,
  output logic            crc_ok,
  output logic [8:0]      frame_length
);

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_TYPE  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CRCL  = 3'd5;
  localparam logic [2:0] PH_CRCH  = 3'd6;

  logic [7:0]  sync_byte;
  logic [7:0]  max_payload;

  logic [2:0]  phase, phase_next;
  logic [7:0]  expected_length, expected_length_next;
  logic [8:0]  body_count, body_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic        accept;
  logic        has_result;
  logic        res_eof;
  logic [7:0]  res_byte;
  logic [7:0]  res_index;
  logic        res_ok;
  logic [8:0]  res_length;
  logic [15:0] crc_upd;
  logic [8:0]  count_inc;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign crc_upd   = slcfr_pkg::crc_step(
                       (phase == PH_LEN) ? slcfr_pkg::CRC_INIT : running_crc, rx_byte);
  assign count_inc = body_count + 9'd1;

  always_comb begin
    phase_next           = phase;
    expected_length_next = expected_length;
    body_count_next      = body_count;
    running_crc_next     = running_crc;
    crc_low_byte_next    = crc_low_byte;
    has_result           = 1'b0;
    res_eof              = 1'b0;
    res_byte             = 8'h00;
    res_index            = 8'h00;
    res_ok               = 1'b0;
    res_length           = 9'd0;
    case (phase)
      PH_SYNC1: begin
        phase_next = (rx_byte == sync_byte) ? PH_SYNC2 : PH_SYNC1;
      end
      PH_SYNC2: begin
        phase_next = (rx_byte == sync_byte) ? PH_LEN : PH_SYNC1;
      end
      PH_LEN: begin
        expected_length_next = rx_byte;
        // drop an oversize frame
        if (rx_byte > max_payload) begin
          phase_next = PH_SYNC1;
        end else begin
          running_crc_next = crc_upd;
          body_count_next  = 9'd0;
          phase_next       = PH_TYPE;
        end
      end
      PH_TYPE: begin
        running_crc_next = crc_upd;
        body_count_next  = 9'd1;
        phase_next       = (expected_length != 8'd0) ? PH_DATA : PH_CRCL;
        has_result       = 1'b1;
        res_byte         = rx_byte;
      end
      PH_DATA: begin
        running_crc_next = crc_upd;
        body_count_next  = count_inc;
        if (count_inc == {1'b0, expected_length} + 9'd1) begin
          phase_next = PH_CRCL;
        end
        has_result = 1'b1;
        res_byte   = rx_byte;
        res_index  = body_count[7:0];
      end
      PH_CRCL: begin
        crc_low_byte_next = rx_byte;
        phase_next        = PH_CRCH;
      end
      PH_CRCH: begin
        has_result = 1'b1;
        res_eof    = 1'b1;
        res_ok     = ({rx_byte, crc_low_byte} == running_crc);
        res_length = body_count;
        phase_next = PH_SYNC1;
      end
      default: begin
        phase_next = PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte   <= slcfr_pkg::SYNC_BYTE_RESET;
      max_payload <= slcfr_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        slcfr_pkg::CFG_SYNC_BYTE:   sync_byte   <= cfg_data;
        slcfr_pkg::CFG_MAX_PAYLOAD: max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC1;
      expected_length <= 8'd0;
      body_count      <= 9'd0;
      running_crc     <= 16'd0;
      crc_low_byte    <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      body_count      <= body_count_next;
      running_crc     <= running_crc_next;
      crc_low_byte    <= crc_low_byte_next;
    end
  end

  // output register: hold while stalled, else load the new result if any
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= accept & has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      end_of_frame <= res_eof;
      payload_byte <= res_byte;
      byte_index   <= res_index;
      crc_ok       <= res_ok;
      frame_length <= res_length;
    end
  end

endmodule

`default_nettype wire

### tb/tb_sync_length_crc_frame_receiver_top.sv
`timescale 1ns / 1ps

module tb_sync_length_crc_frame_receiver_top;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    HUNT_SYNC1, HUNT_SYNC2, GET_LEN, GET_TYPE, GET_DATA, GET_CRC_LO, GET_CRC_HI
  } parse_phase_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;

  typedef struct packed {
    logic       eof;
    logic [7:0] payload;
    logic [7:0] pos;
    logic       ok;
    logic [8:0] flen;
  } frame_result_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       end_of_frame;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic       crc_ok;
  logic [8:0] frame_length;

  sync_length_crc_frame_receiver_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .end_of_frame (end_of_frame),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .crc_ok       (crc_ok),
    .frame_length (frame_length)
  );

  // parser shadow state and register copies
  logic [7:0]    cur_sync = slcfr_pkg::SYNC_BYTE_RESET;
  logic [7:0]    cur_max  = slcfr_pkg::MAX_PAYLOAD_RESET;
  parse_phase_t  parse_phase = HUNT_SYNC1;
  logic [7:0]    exp_len = '0;
  logic [8:0]    body_count = '0;
  logic [15:0]   body_crc = '0;
  logic [7:0]    crc_lo = '0;

  frame_result_t due_results[$];
  int            errors = 0;
  int            stream_items = 0;
  int            burst_left = 0;
  bit            sender_idle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL sync_length_crc_frame_receiver_top");
    $finish;
  end

  // bitwise CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    int          i;
    r = c ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] c);
    frame_result_t r;
    r = '0;
    case (parse_phase)
      HUNT_SYNC1: parse_phase = (c == cur_sync) ? HUNT_SYNC2 : HUNT_SYNC1;
      HUNT_SYNC2: parse_phase = (c == cur_sync) ? GET_LEN : HUNT_SYNC1;
      GET_LEN: begin
        exp_len = c;
        if (c > cur_max) begin
          parse_phase = HUNT_SYNC1;
        end else begin
          body_crc    = crc16_byte(slcfr_pkg::CRC_INIT, c);
          body_count  = '0;
          parse_phase = GET_TYPE;
        end
      end
      GET_TYPE: begin
        body_crc    = crc16_byte(body_crc, c);
        body_count  = 9'd1;
        parse_phase = (exp_len != 8'd0) ? GET_DATA : GET_CRC_LO;
        r.payload   = c;
        due_results.push_back(r);
      end
      GET_DATA: begin
        body_crc   = crc16_byte(body_crc, c);
        r.payload  = c;
        r.pos      = body_count[7:0];
        body_count = body_count + 9'd1;
        if (body_count == {1'b0, exp_len} + 9'd1) parse_phase = GET_CRC_LO;
        due_results.push_back(r);
      end
      GET_CRC_LO: begin
        crc_lo      = c;
        parse_phase = GET_CRC_HI;
      end
      GET_CRC_HI: begin
        r.eof  = 1'b1;
        r.ok   = ({c, crc_lo} == body_crc);
        r.flen = body_count;
        due_results.push_back(r);
        parse_phase = HUNT_SYNC1;
      end
      default: parse_phase = HUNT_SYNC1;
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    frame_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: end_of_frame=%0d payload_byte=%0d", end_of_frame,
               payload_byte);
        errors++;
      end else begin
        e = due_results.pop_front();
        if (end_of_frame !== e.eof) begin
          $error("end_of_frame: expected %0d, got %0d", e.eof, end_of_frame);
          errors++;
        end
        if (payload_byte !== e.payload) begin
          $error("payload_byte: expected %0d, got %0d", e.payload, payload_byte);
          errors++;
        end
        if (byte_index !== e.pos) begin
          $error("byte_index: expected %0d, got %0d", e.pos, byte_index);
          errors++;
        end
        if (crc_ok !== e.ok) begin
          $error("crc_ok: expected %0d, got %0d", e.ok, crc_ok);
          errors++;
        end
        if (frame_length !== e.flen) begin
          $error("frame_length: expected %0d, got %0d", e.flen, frame_length);
          errors++;
        end
      end
    end
  end

  initial begin : stall_pattern
    stall_mode_t mode;
    int          span;
    int          cnt;
    out_stall = 1'b0;
    cnt = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(32, 400);
      repeat (span) begin
        @(negedge clk);
        cnt++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ((cnt % 16) < 12);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      if (sender_idle) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    parse_rx_byte(b);
    stream_items++;
  endtask

  // noise bytes do not count toward the stream length
  task automatic send_noise(input logic [7:0] b);
    send_byte(b);
    stream_items--;
  endtask

  // fill < 0 draws random body bytes
  task automatic send_frame(input int len, input bit bad_crc, input int fill);
    logic [15:0] crc;
    logic [7:0]  b;
    int          i;
    crc = slcfr_pkg::CRC_INIT;
    send_byte(cur_sync);
    send_byte(cur_sync);
    send_byte(8'(len));
    crc = crc16_byte(crc, 8'(len));
    for (i = 0; i <= len; i++) begin
      b   = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      crc = crc16_byte(crc, b);
      send_byte(b);
    end
    if (bad_crc) crc ^= 16'($urandom_range(1, 16'hFFFF));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == slcfr_pkg::CFG_SYNC_BYTE) cur_sync = val;
    else cur_max = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic test_directed_frames();
    send_frame(0, 1'b0, 8'h00);
    send_frame(1, 1'b0, 8'hFF);
    send_frame(0, 1'b1, 8'h5A);
    // oversize length drops the frame
    send_byte(cur_sync);
    send_byte(cur_sync);
    send_byte(cur_max + 8'd1);
    // second sync byte mismatch
    send_byte(cur_sync);
    send_byte(~cur_sync);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(slcfr_pkg::CFG_SYNC_BYTE, 8'h00);
    write_reg(slcfr_pkg::CFG_MAX_PAYLOAD, 8'd0);
    send_frame(0, 1'b0, -1);
    send_frame(0, 1'b1, -1);
    send_byte(cur_sync);
    send_byte(cur_sync);
    send_byte(8'd1);
    write_reg(slcfr_pkg::CFG_SYNC_BYTE, 8'hFF);
    write_reg(slcfr_pkg::CFG_MAX_PAYLOAD, 8'd255);
    send_frame(255, 1'b0, -1);
    drain();
  endtask

  task automatic test_random_stream();
    int ph;
    int target;
    int pick;
    int len;
    int lim;
    int i;
    for (ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        write_reg(slcfr_pkg::CFG_SYNC_BYTE, slcfr_pkg::SYNC_BYTE_RESET);
        write_reg(slcfr_pkg::CFG_MAX_PAYLOAD, slcfr_pkg::MAX_PAYLOAD_RESET);
      end else begin
        if ($urandom_range(0, 3) != 0)
          write_reg(slcfr_pkg::CFG_SYNC_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0)
          write_reg(slcfr_pkg::CFG_MAX_PAYLOAD,
                    ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 40)));
      end
      sender_idle = ($urandom_range(0, 2) != 0);
      target = stream_items + 280;
      while (stream_items < target) begin
        pick = $urandom_range(0, 99);
        lim  = (cur_max < 12) ? cur_max : 12;
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, cur_max)
                                            : $urandom_range(0, lim);
        if (pick < 70) begin
          send_frame(len, $urandom_range(0, 7) == 0, -1);
        end else if (pick < 80) begin
          // cut the frame short; the next sync bytes land inside it
          send_byte(cur_sync);
          send_byte(cur_sync);
          send_byte(8'(len));
          for (i = $urandom_range(0, len); i > 0; i--) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 88) begin
          repeat ($urandom_range(1, 6)) send_noise(8'($urandom_range(0, 255)));
        end else if (pick < 94) begin
          if (cur_max != 8'd255) begin
            send_byte(cur_sync);
            send_byte(cur_sync);
            send_byte(8'($urandom_range(cur_max + 1, 255)));
          end
        end else begin
          send_byte(cur_sync);
          send_byte(cur_sync ^ 8'($urandom_range(1, 255)));
        end
      end
    end
    drain();
  endtask

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = 8'h00;
    in_valid  = 1'b0;
    rx_byte   = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_register_extremes();
    test_random_stream();

    if (errors == 0) begin
      $display("PASS sync_length_crc_frame_receiver_top");
    end else begin
      $display("FAIL sync_length_crc_frame_receiver_top");
    end
    $finish;
  end

endmodule
